/* src/floe_size_moment_defines.svh */
// Assertion helpers for the floe size moment block
`ifndef FLOE_SIZE_MOMENT_DEFINES_SVH
`define FLOE_SIZE_MOMENT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FSMOM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("floe_size_moment: check failed");

// next-cycle implication, disabled in reset
`define FSMOM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("floe_size_moment: check failed");

`endif

/* src/fsmom_pkg.sv */
package fsmom_pkg;

    localparam int LEN_W   = 20;
    localparam int XI_W    = 16;
    localparam int FRAG_W  = 16;
    localparam int ORD_W   = 2;
    localparam int OUT_W   = 44;
    localparam int LVL_W   = 5;
    localparam int T_W     = 22;
    localparam int W_W     = 32;
    localparam int C_W     = 16;
    localparam int NS_W    = 17;
    localparam int ND_W    = 64;
    localparam int SQ_W    = 40;
    localparam int CFG_W   = 20;
    localparam int IDX_W   = 2;

    localparam int DEF_MAX_BREAKS = 16;

    localparam logic [LEN_W-1:0]  RST_MIN_LEN  = 20'd5120;
    localparam logic [XI_W-1:0]   RST_SPLIT    = 16'd512;
    localparam logic [FRAG_W-1:0] RST_FRAG     = 16'd58982;
    localparam logic [LEN_W-1:0]  RST_MIZ      = 20'd64000;

    localparam logic [T_W-1:0]    THRESH_CAP   = 22'h200000;
    localparam logic [OUT_W-1:0]  OUT_MAX      = {OUT_W{1'b1}};
    localparam logic [W_W-1:0]    W_START      = 32'h8000;

    localparam logic [IDX_W-1:0] CFG_MIN_LEN = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SPLIT   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_FRAG    = 2'd2;
    localparam logic [IDX_W-1:0] CFG_MIZ     = 2'd3;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_ZERO,
        OP_UNIF,
        OP_THR,
        OP_INC,
        OP_INIT,
        OP_FAC,
        OP_SHIFT,
        OP_CMUL,
        OP_CLAST,
        OP_PSQ,
        OP_PHI,
        OP_PFIN,
        OP_SAVEPA,
        OP_MAX,
        OP_PMEAN,
        OP_MACL,
        OP_MACH,
        OP_WMUL,
        OP_DIVDM,
        OP_DMLOAD,
        OP_DIVND,
        OP_MEANQ,
        OP_OUT
    } t_op;

    typedef enum logic [1:0] {
        SRC_MIN,
        SRC_LEN,
        SRC_DM
    } t_src;

    typedef struct packed {
        t_op  op;
        t_src src;
    } t_cmd;

    typedef struct packed {
        logic ice;
        logic len_ge_miz;
        logic len_lt_t;
        logic cnt_full;
        logic cnt_zero;
        logic need_norm;
        logic m_lt_cnt;
        logic ns_zero;
        logic div_done;
    } t_status;

endpackage

/* src/fsmom_div.sv */
module fsmom_div
    import fsmom_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [ND_W-1:0] i_dividend,
    input  logic [NS_W-1:0] i_divisor,
    output logic            o_done,
    output logic [ND_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(ND_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [NS_W-1:0]   r_rem;
    logic [NS_W-1:0]   r_dvs;
    logic [ND_W-1:0]   r_q;
    logic [NS_W:0]     rem_sh;
    logic [NS_W+1:0]   diff;

    // one quotient bit per cycle, restoring
    assign rem_sh = {r_rem, r_q[ND_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(ND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            if (!diff[NS_W+1]) begin
                r_rem <= diff[NS_W-1:0];
                r_q   <= {r_q[ND_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[NS_W-1:0];
                r_q   <= {r_q[ND_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* src/fsmom_dp.sv */
module fsmom_dp
    import fsmom_pkg::*;
#(
    parameter int MAX_BREAKS = DEF_MAX_BREAKS
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_ice_present,
    input  logic [LEN_W-1:0]  i_floe_length,
    input  logic [ORD_W-1:0]  i_moment_order,
    input  t_cmd              i_cmd,
    output t_status           o_sts,
    output logic [OUT_W-1:0]  o_mean_power,
    output logic [LVL_W-1:0]  o_break_levels,
    output logic              o_breaks_clipped
);

    localparam int CNT_W = $clog2(MAX_BREAKS + 1);

    logic [LEN_W-1:0]  r_min;
    logic [XI_W-1:0]   r_split;
    logic [FRAG_W-1:0] r_frag;
    logic [LEN_W-1:0]  r_miz;

    logic              r_ice;
    logic [LEN_W-1:0]  r_len;
    logic [ORD_W-1:0]  r_order;
    logic [T_W-1:0]    r_t;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_m;
    logic              r_clip;
    logic [W_W-1:0]    r_ffac;
    logic [NS_W-1:0]   r_omf;
    logic [XI_W-1:0]   r_div;
    logic [W_W-1:0]    r_w;
    logic [NS_W-1:0]   r_ns;
    logic [ND_W-1:0]   r_nd;
    logic [ND_W-1:0]   r_dm;
    logic [C_W-1:0]    r_c;
    logic [SQ_W-1:0]   r_sq;
    logic [SQ_W-1:0]   r_ph;
    logic [OUT_W-1:0]  r_pw;
    logic [OUT_W-1:0]  r_pa;
    logic [OUT_W-1:0]  r_mean;
    logic [OUT_W-1:0]  r_o_mean;
    logic [LVL_W-1:0]  r_o_lvl;
    logic              r_o_clip;

    logic [T_W+XI_W-1:0]  thr_prod;
    logic [T_W+XI_W-9:0]  thr_sh;
    logic [T_W-1:0]       n_t;
    logic [W_W-1:0]       fac1;
    logic [W_W+XI_W-1:0]  fac2;
    logic [C_W+NS_W-1:0]  cprod;
    logic [C_W+W_W-1:0]   wprod;
    logic [LEN_W-1:0]     pl;
    logic [SQ_W-1:0]      sq;
    logic [SQ_W-1:0]      ph;
    logic [SQ_W-1:0]      plo;
    logic [SQ_W+19:0]     cube;
    logic [OUT_W-1:0]     pw;
    logic [C_W+21:0]      macl;
    logic [C_W+21:0]      mach;
    logic                 div_start;
    logic [ND_W-1:0]      div_num;
    logic [NS_W-1:0]      div_den;
    logic                 div_done;
    logic [ND_W-1:0]      div_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= RST_MIN_LEN;
            r_split <= RST_SPLIT;
            r_frag  <= RST_FRAG;
            r_miz   <= RST_MIZ;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_LEN: r_min   <= i_cfg_data[LEN_W-1:0];
                CFG_SPLIT:   r_split <= i_cfg_data[XI_W-1:0];
                CFG_FRAG:    r_frag  <= i_cfg_data[FRAG_W-1:0];
                CFG_MIZ:     r_miz   <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign thr_prod = r_t * r_split;
    assign thr_sh   = thr_prod[T_W+XI_W-1:8];
    assign n_t      = (thr_sh > (T_W+XI_W-8)'(THRESH_CAP)) ? THRESH_CAP : thr_sh[T_W-1:0];
    assign fac1     = r_frag * r_split;
    assign fac2     = r_ffac * r_split;
    assign cprod    = r_w[C_W-1:0] * r_omf;
    assign wprod    = r_w[C_W-1:0] * r_ffac;

    always_comb begin
        case (i_cmd.src)
            SRC_MIN: pl = r_min;
            SRC_LEN: pl = r_len;
            default: pl = r_dm[LEN_W-1:0];
        endcase
    end

    // L^3 split in two 20x20 halves; the upper half is registered in r_ph before the sum
    assign sq   = pl * pl;
    assign ph   = r_sq[SQ_W-1:20] * pl;
    assign plo  = r_sq[19:0] * pl;
    assign cube = {r_ph, 20'd0} + {20'd0, plo};

    always_comb begin
        case (r_order)
            2'd0:    pw = OUT_W'(256);
            2'd1:    pw = OUT_W'(pl);
            2'd2:    pw = OUT_W'(r_sq[SQ_W-1:8]);
            default: pw = cube[SQ_W+19:16];
        endcase
    end

    assign macl = r_c * r_pw[21:0];
    assign mach = r_c * r_pw[OUT_W-1:22];

    assign div_start = (i_cmd.op == OP_DIVDM) || (i_cmd.op == OP_DIVND);
    assign div_num   = (i_cmd.op == OP_DIVDM) ? {r_dm[ND_W-9:0], 8'd0} : r_nd;
    assign div_den   = (i_cmd.op == OP_DIVDM) ? {1'b0, r_div} : r_ns;

    fsmom_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_ice   <= i_ice_present;
                r_len   <= i_floe_length;
                r_order <= i_moment_order;
                r_t     <= T_W'(r_min);
                r_cnt   <= '0;
                r_clip  <= 1'b0;
            end
            OP_ZERO: r_mean <= '0;
            OP_UNIF: r_mean <= OUT_W'(r_len);
            OP_THR:  r_t <= n_t;
            OP_INC: begin
                if (r_cnt == CNT_W'(MAX_BREAKS)) begin
                    r_clip <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            OP_INIT: begin
                r_ffac <= fac1;
                r_omf  <= NS_W'(65536) - NS_W'(r_frag);
                r_div  <= (r_split == '0) ? XI_W'(1) : r_split;
                r_w    <= W_START;
                r_ns   <= '0;
                r_nd   <= '0;
                r_dm   <= ND_W'(r_len);
                r_m    <= '0;
            end
            OP_FAC:  r_ffac <= fac2[W_W+XI_W-1:16];
            OP_SHIFT: begin
                r_w  <= r_w >> 1;
                r_ns <= r_ns >> 1;
                r_nd <= r_nd >> 1;
            end
            OP_CMUL: begin
                r_c  <= cprod[31:16];
                r_ns <= r_ns + NS_W'(cprod[31:16]);
            end
            OP_CLAST: begin
                r_c  <= r_w[C_W-1:0];
                r_ns <= r_ns + NS_W'(r_w[C_W-1:0]);
            end
            OP_PSQ:    r_sq <= sq;
            OP_PHI:    r_ph <= ph;
            OP_PFIN:   r_pw <= pw;
            OP_SAVEPA: r_pa <= r_pw;
            OP_MAX:    r_mean <= (r_pa > r_pw) ? r_pa : r_pw;
            OP_PMEAN:  r_mean <= r_pw;
            OP_MACL:   r_nd <= r_nd + ND_W'(macl);
            OP_MACH:   r_nd <= r_nd + ND_W'({mach, 22'd0});
            OP_WMUL:   r_w <= wprod[C_W+W_W-1:16];
            OP_DMLOAD: begin
                r_dm <= div_q;
                r_m  <= r_m + 1'b1;
            end
            OP_MEANQ:  r_mean <= (div_q[ND_W-1:OUT_W] != '0) ? OUT_MAX : div_q[OUT_W-1:0];
            OP_OUT: begin
                r_o_mean <= r_mean;
                r_o_lvl  <= LVL_W'(r_cnt);
                r_o_clip <= r_clip;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_sts.ice        = r_ice;
        o_sts.len_ge_miz = (r_len >= r_miz);
        o_sts.len_lt_t   = (T_W'(r_len) < r_t);
        o_sts.cnt_full   = (r_cnt == CNT_W'(MAX_BREAKS));
        o_sts.cnt_zero   = (r_cnt == '0);
        o_sts.need_norm  = (r_w[W_W-1:16] != '0) || r_ns[NS_W-1];
        o_sts.m_lt_cnt   = (r_m < r_cnt);
        o_sts.ns_zero    = (r_ns == '0);
        o_sts.div_done   = div_done;
    end

    assign o_mean_power     = r_o_mean;
    assign o_break_levels   = r_o_lvl;
    assign o_breaks_clipped = r_o_clip;

endmodule

/* src/fsmom_ctrl.sv */
module fsmom_ctrl
    import fsmom_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_sts,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECIDE, S_THR, S_CHK, S_INIT, S_FAC, S_NORM,
        S_PSQ, S_PHI, S_PFIN, S_SAVEPA, S_MAX, S_PMEAN,
        S_MACL, S_MACH, S_WMUL, S_DSTART, S_DWAIT,
        S_FINAL, S_FWAIT, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        R_PA, R_MAX, R_MAC, R_MEAN
    } t_ret;

    t_state r_state, n_state;
    t_ret   r_ret, n_ret;
    t_src   r_src, n_src;
    logic   r_out_valid, n_out_valid;
    t_op    op;

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_src       = r_src;
        n_out_valid = r_out_valid;
        op          = OP_NOP;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    op      = OP_LOAD;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_sts.ice) begin
                    op      = OP_ZERO;
                    n_state = S_DONE;
                end else if (i_sts.len_ge_miz) begin
                    op      = OP_UNIF;
                    n_state = S_DONE;
                end else begin
                    n_state = S_THR;
                end
            end
            S_THR: begin
                op      = OP_THR;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_sts.len_lt_t) begin
                    if (i_sts.cnt_zero) begin
                        n_src   = SRC_MIN;
                        n_ret   = R_PA;
                        n_state = S_PSQ;
                    end else begin
                        n_state = S_INIT;
                    end
                end else begin
                    op      = OP_INC;
                    n_state = i_sts.cnt_full ? S_INIT : S_THR;
                end
            end
            S_INIT: begin
                op      = OP_INIT;
                n_state = S_FAC;
            end
            S_FAC: begin
                op      = OP_FAC;
                n_state = S_NORM;
            end
            S_NORM: begin
                if (i_sts.need_norm) begin
                    op = OP_SHIFT;
                end else begin
                    op      = i_sts.m_lt_cnt ? OP_CMUL : OP_CLAST;
                    n_src   = SRC_DM;
                    n_ret   = R_MAC;
                    n_state = S_PSQ;
                end
            end
            S_PSQ: begin
                op      = OP_PSQ;
                n_state = S_PHI;
            end
            S_PHI: begin
                op      = OP_PHI;
                n_state = S_PFIN;
            end
            S_PFIN: begin
                op = OP_PFIN;
                case (r_ret)
                    R_PA:    n_state = S_SAVEPA;
                    R_MAX:   n_state = S_MAX;
                    R_MAC:   n_state = S_MACL;
                    default: n_state = S_PMEAN;
                endcase
            end
            S_SAVEPA: begin
                op      = OP_SAVEPA;
                n_src   = SRC_LEN;
                n_ret   = R_MAX;
                n_state = S_PSQ;
            end
            S_MAX: begin
                op      = OP_MAX;
                n_state = S_DONE;
            end
            S_PMEAN: begin
                op      = OP_PMEAN;
                n_state = S_DONE;
            end
            S_MACL: begin
                op      = OP_MACL;
                n_state = S_MACH;
            end
            S_MACH: begin
                op      = OP_MACH;
                n_state = i_sts.m_lt_cnt ? S_WMUL : S_FINAL;
            end
            S_WMUL: begin
                op      = OP_WMUL;
                n_state = S_DSTART;
            end
            S_DSTART: begin
                op      = OP_DIVDM;
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_sts.div_done) begin
                    op      = OP_DMLOAD;
                    n_state = S_NORM;
                end
            end
            S_FINAL: begin
                if (i_sts.ns_zero) begin
                    n_src   = SRC_LEN;
                    n_ret   = R_MEAN;
                    n_state = S_PSQ;
                end else begin
                    op      = OP_DIVND;
                    n_state = S_FWAIT;
                end
            end
            S_FWAIT: begin
                if (i_sts.div_done) begin
                    op      = OP_MEANQ;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    op          = OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= R_PA;
            r_src       <= SRC_MIN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_src       <= n_src;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd.op    = op;
    assign o_cmd.src   = r_src;

endmodule

/* src/floe_size_moment.sv */
// Channel | Handshake               | Payload
// in      | i_in_valid / o_in_ready | i_ice_present, i_floe_length, i_moment_order
// out     | o_out_valid / i_out_ready | o_mean_power, o_break_levels, o_breaks_clipped
// cfg     | i_cfg_we (no wait)      | i_cfg_idx, i_cfg_data
//
// One cell at a time. No ice or uniform case: load, decide and output only. Otherwise
// a threshold step and check per level, then per break level the normalise shifts,
// power (PSQ, PHI, PFIN), accumulate (MACL, MACH) and a 64-bit divide,
// plus a final 64-bit divide on the shared one-bit-per-cycle divider.
// Reset synchronous, active low: controller idles, config registers take defaults.
// A held result does not block the datapath until the next result is ready; the next
// beat is taken once the previous result has moved to the output register.
module floe_size_moment
    import fsmom_pkg::*;
#(
    parameter int MAX_BREAKS = DEF_MAX_BREAKS
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_ice_present,
    input  logic [LEN_W-1:0] i_floe_length,
    input  logic [ORD_W-1:0] i_moment_order,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [OUT_W-1:0] o_mean_power,
    output logic [LVL_W-1:0] o_break_levels,
    output logic             o_breaks_clipped
);

    t_cmd    cmd;
    t_status sts;

    // sequencer: threshold count, weight loop, final divide
    fsmom_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // registers, multipliers and shared divider
    fsmom_dp #(
        .MAX_BREAKS (MAX_BREAKS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_ice_present    (i_ice_present),
        .i_floe_length    (i_floe_length),
        .i_moment_order   (i_moment_order),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_mean_power     (o_mean_power),
        .o_break_levels   (o_break_levels),
        .o_breaks_clipped (o_breaks_clipped)
    );

endmodule

/* src/fsmom_chk.sv */
`include "floe_size_moment_defines.svh"

module fsmom_chk
    import fsmom_pkg::*;
#(
    parameter int MAX_BREAKS = DEF_MAX_BREAKS
)
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cfg_we,
    input logic [IDX_W-1:0] i_cfg_idx,
    input logic [CFG_W-1:0] i_cfg_data,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             i_ice_present,
    input logic [LEN_W-1:0] i_floe_length,
    input logic [ORD_W-1:0] i_moment_order,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [OUT_W-1:0] o_mean_power,
    input logic [LVL_W-1:0] o_break_levels,
    input logic             o_breaks_clipped
);

    // stalled result beat holds
    `FSMOM_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_mean_power))
    // clipped count sits at the limit
    `FSMOM_ASSERT_IMP(a_clip_lvl, o_out_valid && o_breaks_clipped, o_break_levels == LVL_W'(MAX_BREAKS))
    // one cell at a time
    `FSMOM_ASSERT_NXT(a_busy, i_in_valid && o_in_ready, !o_in_ready)
    // a fresh result leaves the block idle
    `FSMOM_ASSERT_IMP(a_idle_out, $rose(o_out_valid), o_in_ready)

endmodule

bind floe_size_moment fsmom_chk #(.MAX_BREAKS(MAX_BREAKS)) u_chk (.*);

/* test/floe_size_moment_tb.sv */
`timescale 1ns / 1ps

module floe_size_moment_tb;
    import fsmom_pkg::*;

    // Expected result of one cell
    typedef struct {
        logic [OUT_W-1:0] mean;
        logic [LVL_W-1:0] lvls;
        logic             clip;
    } t_moment;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    logic             i_ice_present;
    logic [LEN_W-1:0] i_floe_length;
    logic [ORD_W-1:0] i_moment_order;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [OUT_W-1:0] o_mean_power;
    logic [LVL_W-1:0] o_break_levels;
    logic             o_breaks_clipped;

    // Predictor's own copy of the registers
    logic [LEN_W-1:0]  min_len;
    logic [XI_W-1:0]   xi;
    logic [FRAG_W-1:0] frag;
    logic [LEN_W-1:0]  miz;

    t_moment moment_q[$];
    int      n_errors;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      recv_hold;

    floe_size_moment dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("simulation failed");
        $finish;
    end

    // Powered length in Q.8
    function automatic logic [63:0] pow_q8(input logic [63:0] len, input logic [1:0] ord);
        logic [63:0] l;
        l = len & 64'hFFFFF;
        case (ord)
            2'd0:    return 64'd256;
            2'd1:    return l;
            2'd2:    return (l * l) >> 8;
            default: return (l * l * l) >> 16;
        endcase
    endfunction

    function automatic t_moment predict_moment(input logic ice, input logic [LEN_W-1:0] len,
                                               input logic [1:0] ord);
        t_moment     r;
        logic [63:0] t, g, q, w, ns, nd, dm, dv, c, pa, pb, mean;
        int          cnt;
        mean = 0;
        cnt = 0;
        r.clip = 1'b0;
        if (!ice) begin
            mean = 0;
        end else if (len >= miz) begin
            mean = len;
        end else begin
            t = min_len;
            while (cnt <= DEF_MAX_BREAKS) begin
                t = (t * xi) >> 8;
                if (t > 64'h200000) t = 64'h200000;
                if (len < t) break;
                cnt++;
            end
            if (cnt > DEF_MAX_BREAKS) begin
                cnt = DEF_MAX_BREAKS;
                r.clip = 1'b1;
            end
            if (cnt == 0) begin
                pa = pow_q8(min_len, ord);
                pb = pow_q8(len, ord);
                mean = pa > pb ? pa : pb;
            end else begin
                g = (64'(frag) * xi * xi) >> 16;
                q = 64'd65536 - frag;
                dv = xi != 0 ? 64'(xi) : 64'd1;
                w = 64'h8000;
                ns = 0;
                nd = 0;
                dm = len;
                for (int m = 0; m <= cnt; m++) begin
                    // renormalise weight and sums together
                    while (w >= 64'h10000 || ns >= 64'h10000) begin
                        w = w >> 1; ns = ns >> 1; nd = nd >> 1;
                    end
                    if (m == cnt) begin
                        ns += w;
                        nd += w * pow_q8(dm, ord);
                    end else begin
                        c = (w * q) >> 16;
                        ns += c;
                        nd += c * pow_q8(dm, ord);
                        w = (w * g) >> 16;
                        dm = (dm * 256) / dv;
                    end
                end
                mean = ns != 0 ? nd / ns : pow_q8(len, ord);
            end
        end
        r.mean = mean > 64'hFFFFFFFFFFF ? OUT_MAX : mean[OUT_W-1:0];
        r.lvls = cnt[LVL_W-1:0];
        return r;
    endfunction

    // Register write, block idle; write enable dropped by the caller
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_MIN_LEN: min_len = val;
            CFG_SPLIT:   xi = val[XI_W-1:0];
            CFG_FRAG:    frag = val[FRAG_W-1:0];
            default:     miz = val;
        endcase
    endtask

    task automatic write_all(input logic [CFG_W-1:0] ml, input logic [CFG_W-1:0] sf,
                             input logic [CFG_W-1:0] fr, input logic [CFG_W-1:0] mz);
        write_reg(CFG_MIN_LEN, ml);
        write_reg(CFG_SPLIT, sf);
        write_reg(CFG_FRAG, fr);
        write_reg(CFG_MIZ, mz);
        i_cfg_we <= 1'b0;
    endtask

    // One input beat; valid held until taken, dropped by the next idle or drain
    task automatic send_cell(input logic ice, input logic [LEN_W-1:0] len,
                             input logic [1:0] ord);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_ice_present  <= ice;
        i_floe_length  <= len;
        i_moment_order <= ord;
        do @(posedge i_clk); while (!o_in_ready);
        moment_q.push_back(predict_moment(ice, len, ord));
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (moment_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (recv_hold > 0) begin
            recv_hold   <= recv_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_moment e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (moment_q.size() == 0) begin
                $display("%0t: unexpected beat mean %0d", $time, o_mean_power);
                n_errors++;
            end else begin
                e = moment_q.pop_front();
                if (o_mean_power !== e.mean) begin
                    $display("%0t: mean_power exp %0d got %0d", $time, e.mean, o_mean_power);
                    n_errors++;
                end
                if (o_break_levels !== e.lvls) begin
                    $display("%0t: break_levels exp %0d got %0d", $time, e.lvls,
                             o_break_levels);
                    n_errors++;
                end
                if (o_breaks_clipped !== e.clip) begin
                    $display("%0t: breaks_clipped exp %0d got %0d", $time, e.clip,
                             o_breaks_clipped);
                    n_errors++;
                end
            end
        end
    end

    // Special cases at reset settings and at the register extremes
    task automatic test_directed;
        send_cell(1'b0, 20'hFFFFF, 2'd3);
        send_cell(1'b1, 20'd64000, 2'd2);
        send_cell(1'b1, 20'hFFFFF, 2'd0);
        send_cell(1'b1, 20'd0, 2'd1);
        send_cell(1'b1, 20'd100, 2'd3);
        for (int o = 0; o < 4; o++) send_cell(1'b1, 20'd30000, o[1:0]);
        send_cell(1'b1, 20'd63999, 2'd3);
        drain();
        // split factor too small: every reaching length is clipped
        write_all(20'd1, 20'd256, 20'd65535, 20'hFFFFF);
        send_cell(1'b1, 20'd5, 2'd3);
        send_cell(1'b1, 20'hFFFFE, 2'd2);
        drain();
        write_all(20'd0, 20'd0, 20'd0, 20'd0);
        send_cell(1'b1, 20'd0, 2'd1);
        drain();
        write_all(20'd0, 20'd0, 20'd0, 20'hFFFFF);
        send_cell(1'b1, 20'd1000, 2'd2);
        send_cell(1'b1, 20'hFFFFE, 2'd3);
        drain();
        write_all(20'hFFFFF, 20'd65535, 20'd65535, 20'hFFFFF);
        send_cell(1'b1, 20'hFFFFE, 2'd3);
        drain();
        write_all(20'd1, 20'd65535, 20'd0, 20'hFFFFF);
        send_cell(1'b1, 20'hFFFFE, 2'd3);
        send_cell(1'b1, 20'd300, 2'd2);
        drain();
    endtask

    // Random cells under one register setting
    task automatic test_random_phase(input int n);
        for (int i = 0; i < n; i++)
            send_cell($urandom_range(15) != 0,
                      ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(70000)),
                      2'($urandom));
        drain();
    endtask

    task automatic test_random;
        for (int p = 0; p < 12; p++) begin
            case (p % 4)
                0: write_all(CFG_W'(RST_MIN_LEN), CFG_W'(RST_SPLIT), CFG_W'(RST_FRAG),
                             CFG_W'(RST_MIZ));
                1: write_all(CFG_W'($urandom_range(20, 4000)), CFG_W'($urandom_range(257, 1200)),
                             CFG_W'($urandom), CFG_W'($urandom_range(20000, 1048575)));
                2: write_all(CFG_W'($urandom_range(1, 1048575)), CFG_W'($urandom_range(0, 65535)),
                             CFG_W'($urandom), CFG_W'($urandom));
                default: write_all(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom));
            endcase
            if (p == 4) begin send_idle_pct = 48; recv_idle_pct = 12; end
            if (p == 8) begin send_idle_pct = 0; recv_idle_pct = 0; end
            test_random_phase(85);
        end
    endtask

    // Long receiver hold-off fills the block; then sender waits for all results
    task automatic test_backpressure;
        write_all(CFG_W'(RST_MIN_LEN), CFG_W'(RST_SPLIT), CFG_W'(RST_FRAG), CFG_W'(RST_MIZ));
        recv_hold = 3000;
        for (int i = 0; i < 10; i++) send_cell(1'b1, 20'($urandom_range(60000)), 2'($urandom));
        drain();
        for (int i = 0; i < 5; i++) send_cell(1'($urandom_range(1)), 20'($urandom), 2'($urandom));
        drain();
    endtask

    initial begin
        n_errors = 0;
        send_idle_pct = 12;
        recv_idle_pct = 48;
        recv_hold = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_ice_present = 1'b0;
        i_floe_length = '0;
        i_moment_order = '0;
        i_out_ready = 1'b0;
        min_len = RST_MIN_LEN;
        xi = RST_SPLIT;
        frag = RST_FRAG;
        miz = RST_MIZ;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/fsmom_pkg.sv
src/fsmom_div.sv
src/fsmom_dp.sv
src/fsmom_ctrl.sv
src/floe_size_moment.sv
src/fsmom_chk.sv
test/floe_size_moment_tb.sv
